FILE: src/cnlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnlc_pkg
// Shared widths, codes and control types of the card number classifier.
// ----------------------------------------------------------------------------
package cnlc_pkg;

  localparam int CARD_W        = 54;
  localparam int BCD_DIGITS    = 18;
  localparam int BCD_W         = 4 * BCD_DIGITS;
  localparam int BITS_PER_STEP = 3;
  localparam int CONV_STEPS    = CARD_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);
  localparam int PAIR_W        = $clog2(BCD_DIGITS / 2);
  localparam int COUNT_W       = 5;

  localparam logic [COUNT_W-1:0] MAX_DIGITS = 5'd16;
  localparam logic [COUNT_W-1:0] LEN_13     = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15     = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16     = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_LIM  = 5'd17;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_P34_37 = 2'd1;
  localparam logic [1:0] KIND_P51_55 = 2'd2;
  localparam logic [1:0] KIND_P4     = 2'd3;

  typedef struct packed {
    logic load;
    logic conv;
    logic scan;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic rest_zero;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/cnlc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnlc_ctrl
// Sequencer: load, binary to decimal steps, digit pair scan, result transfer.
// ----------------------------------------------------------------------------
module cnlc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire cnlc_pkg::sts_t sts,
  output cnlc_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [cnlc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (step_r == cnlc_pkg::STEP_W'(cnlc_pkg::CONV_STEPS - 1)) begin
          state_nxt = S_SCAN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.rest_zero) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.fin | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: src/cnlc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnlc_dp
// Datapath: shift-add-3 decimal conversion, Luhn mod-10 scan, classification.
// ----------------------------------------------------------------------------
module cnlc_dp (
  input  wire logic                        clk,
  input  wire cnlc_pkg::cmd_t              cmd,
  output cnlc_pkg::sts_t                   sts,
  input  wire logic [cnlc_pkg::CARD_W-1:0] in_card_value,
  output logic [1:0]                       out_card_kind,
  output logic                             out_checksum_ok,
  output logic [cnlc_pkg::COUNT_W-1:0]     out_digit_count
);

  localparam int WORK_W = cnlc_pkg::BCD_W + cnlc_pkg::CARD_W;

  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] p;
    p = {d, 1'b0};
    if (p >= 5'd10) begin
      p = p - 5'd9;
    end
    return p[3:0];
  endfunction

  function automatic logic [3:0] mod10_add(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[3:0];
  endfunction

  logic [cnlc_pkg::CARD_W-1:0]  bin_r, bin_nxt;
  logic [cnlc_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [3:0]                   sum_r, sum_nxt;
  logic [cnlc_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]                   lead_hi_r, lead_hi_nxt;
  logic [3:0]                   lead_lo_r, lead_lo_nxt;
  logic [3:0]                   prev_r, prev_nxt;
  logic [cnlc_pkg::PAIR_W-1:0]  pair_r, pair_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic                         ok_r, ok_nxt;
  logic [cnlc_pkg::COUNT_W-1:0] count_r, count_nxt;

  logic [WORK_W-1:0]            work;
  logic [3:0]                   dig_lo, dig_hi;
  logic [cnlc_pkg::COUNT_W-1:0] cnt_even;
  logic                         len_ok;
  logic                         sum_ok;

  always_comb begin
    work = {bcd_r, bin_r};
    for (int s = 0; s < cnlc_pkg::BITS_PER_STEP; s++) begin
      for (int d = 0; d < cnlc_pkg::BCD_DIGITS; d++) begin
        if (work[cnlc_pkg::CARD_W + 4*d +: 4] >= 4'd5) begin
          work[cnlc_pkg::CARD_W + 4*d +: 4] = work[cnlc_pkg::CARD_W + 4*d +: 4] + 4'd3;
        end
      end
      work = {work[WORK_W-2:0], 1'b0};
    end
  end

  assign dig_lo   = bcd_r[3:0];
  assign dig_hi   = bcd_r[7:4];
  assign cnt_even = {pair_r, 1'b0};
  assign sum_ok   = (sum_r == 4'd0);
  assign len_ok   = (cnt_r <= cnlc_pkg::MAX_DIGITS) &&
                    ((cnt_r == cnlc_pkg::LEN_13) || (cnt_r == cnlc_pkg::LEN_15) ||
                     (cnt_r == cnlc_pkg::LEN_16));

  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    lead_hi_nxt = lead_hi_r;
    lead_lo_nxt = lead_lo_r;
    prev_nxt    = prev_r;
    pair_nxt    = pair_r;
    kind_nxt    = kind_r;
    ok_nxt      = ok_r;
    count_nxt   = count_r;
    if (cmd.load) begin
      bin_nxt     = in_card_value;
      bcd_nxt     = '0;
      sum_nxt     = '0;
      cnt_nxt     = '0;
      lead_hi_nxt = '0;
      lead_lo_nxt = '0;
      prev_nxt    = '0;
      pair_nxt    = '0;
    end else if (cmd.conv) begin
      bcd_nxt = work[WORK_W-1 -: cnlc_pkg::BCD_W];
      bin_nxt = work[cnlc_pkg::CARD_W-1:0];
    end else if (cmd.scan) begin
      sum_nxt  = mod10_add(mod10_add(sum_r, dig_lo), luhn_double(dig_hi));
      bcd_nxt  = {8'd0, bcd_r[cnlc_pkg::BCD_W-1:8]};
      prev_nxt = dig_hi;
      pair_nxt = pair_r + 1'b1;
      if (dig_hi != 4'd0) begin
        cnt_nxt     = cnt_even + 5'd2;
        lead_hi_nxt = dig_hi;
        lead_lo_nxt = dig_lo;
      end else if (dig_lo != 4'd0) begin
        cnt_nxt     = cnt_even + 5'd1;
        lead_hi_nxt = dig_lo;
        lead_lo_nxt = prev_r;
      end
    end else if (cmd.fin) begin
      ok_nxt    = sum_ok;
      count_nxt = cnt_r;
      kind_nxt  = cnlc_pkg::KIND_NONE;
      if (sum_ok && len_ok) begin
        if (lead_hi_r == 4'd3 && (lead_lo_r == 4'd4 || lead_lo_r == 4'd7)) begin
          kind_nxt = cnlc_pkg::KIND_P34_37;
        end else if (lead_hi_r == 4'd5 && lead_lo_r >= 4'd1 && lead_lo_r <= 4'd5) begin
          kind_nxt = cnlc_pkg::KIND_P51_55;
        end else if (lead_hi_r == 4'd4) begin
          kind_nxt = cnlc_pkg::KIND_P4;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    sum_r     <= sum_nxt;
    cnt_r     <= cnt_nxt;
    lead_hi_r <= lead_hi_nxt;
    lead_lo_r <= lead_lo_nxt;
    prev_r    <= prev_nxt;
    pair_r    <= pair_nxt;
    kind_r    <= kind_nxt;
    ok_r      <= ok_nxt;
    count_r   <= count_nxt;
  end

  assign sts.rest_zero   = (bcd_r[cnlc_pkg::BCD_W-1:8] == '0);
  assign out_card_kind   = kind_r;
  assign out_checksum_ok = ok_r;
  assign out_digit_count = count_r;

endmodule

`default_nettype wire

FILE: src/card_number_luhn_classifier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_core
// Luhn mod-10 check, digit count and prefix class of one binary card number.
// ----------------------------------------------------------------------------
// One card number is handled at a time. After the input transfer, the 54-bit
// value is converted to decimal, three bits per cycle through a shift-add-3
// unit; a scan then takes two digits per cycle from the right and stops
// after the highest nonzero pair; a final step loads the result register.
// The next item is taken in the cycle after the result is loaded, while the
// result waits in its register for the consumer. The load is held off, and
// the item takes longer, while an earlier result still waits there.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cnlc_pkg::CARD_W-1:0] in_card_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_card_kind,
  output logic                             out_checksum_ok,
  output logic [cnlc_pkg::COUNT_W-1:0]     out_digit_count
);

  cnlc_pkg::cmd_t cmd;
  cnlc_pkg::sts_t sts;

  cnlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cnlc_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_card_value   (in_card_value),
    .out_card_kind   (out_card_kind),
    .out_checksum_ok (out_checksum_ok),
    .out_digit_count (out_digit_count)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after transfer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_count <= cnlc_pkg::COUNT_LIM))
    else $error("digit count out of range");

  a_kind_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_card_kind != cnlc_pkg::KIND_NONE)) |-> out_checksum_ok)
    else $error("classified without checksum");

  a_kind_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_card_kind != cnlc_pkg::KIND_NONE)) |->
    ((out_digit_count == cnlc_pkg::LEN_13) || (out_digit_count == cnlc_pkg::LEN_15) ||
     (out_digit_count == cnlc_pkg::LEN_16)))
    else $error("classified with bad length");
`endif

endmodule

`default_nettype wire
